>>> rtl/tcp_pdu_header_data_splitter_unit_defines.svh
// assertion macros for the tcp pdu header/data splitter
// no dependencies; included by the checker only
`ifndef TCP_PDU_HEADER_DATA_SPLITTER_UNIT_DEFINES_SVH
`define TCP_PDU_HEADER_DATA_SPLITTER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TPDS_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tpds check failed");

// next-cycle implication, disabled in reset
`define TPDS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tpds check failed");

`endif

>>> rtl/tpds_pkg.sv
// shared types and constants for the tcp pdu header/data splitter
// no dependencies
package tpds_pkg;

    localparam int unsigned COMMON_HDR_BYTES = 8;
    localparam int unsigned QUEUE_DEPTH      = 2;

    // pdu type codes
    localparam logic [7:0] PDU_IC_REQ       = 8'd0;
    localparam logic [7:0] PDU_IC_RESP      = 8'd1;
    localparam logic [7:0] PDU_H2C_TERM_REQ = 8'd2;
    localparam logic [7:0] PDU_C2H_TERM_REQ = 8'd3;
    localparam logic [7:0] PDU_CAPSULE_CMD  = 8'd4;
    localparam logic [7:0] PDU_CAPSULE_RESP = 8'd5;
    localparam logic [7:0] PDU_H2C_DATA     = 8'd6;
    localparam logic [7:0] PDU_C2H_DATA     = 8'd7;
    localparam logic [7:0] PDU_R2T          = 8'd9;

    // configuration register indexes
    localparam logic CFG_CONTROL_ROUTE = 1'b0;
    localparam logic CFG_PAYLOAD_ROUTE = 1'b1;

    typedef enum logic [1:0] {
        OUT_NEED_MORE = 2'd0,
        OUT_CONSUMED  = 2'd1,
        OUT_ERROR     = 2'd2
    } outcome_t;

    // what the header fields say, if the request starts a new pdu
    typedef enum logic [1:0] {
        KIND_SHORT,
        KIND_ERROR,
        KIND_NEW
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [31:0] head_len;
        logic [31:0] pdu_len;
        logic [15:0] seg_len;
    } queue_item_t;

endpackage

>>> rtl/tpds_front.sv
// front stage: takes segment descriptors and classifies the common header
// depends on tpds_pkg
module tpds_front (
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [79:0]           s_axis_tdata,
    input  logic                  q_ready,
    output logic                  q_push,
    output tpds_pkg::queue_item_t q_item
);

    logic [15:0] seg_len;
    logic [15:0] parse_start;
    logic [7:0]  hdr_type;
    logic [7:0]  hdr_pdo;
    logic [31:0] hdr_plen;
    logic [16:0] seg_left;
    logic        pdo_bad;

    assign seg_len     = s_axis_tdata[15:0];
    assign parse_start = s_axis_tdata[31:16];
    assign hdr_type    = s_axis_tdata[39:32];
    assign hdr_pdo     = s_axis_tdata[47:40];
    assign hdr_plen    = s_axis_tdata[79:48];

    assign s_axis_tready = q_ready;
    assign q_push        = s_axis_tvalid && q_ready;

    assign seg_left = {1'b0, seg_len} - {1'b0, parse_start};
    assign pdo_bad  = ({24'b0, hdr_pdo} > hdr_plen)
                   || (hdr_pdo < 8'(tpds_pkg::COMMON_HDR_BYTES));

    always_comb
    begin
        q_item.seg_len  = seg_len;
        q_item.pdu_len  = hdr_plen;
        q_item.head_len = hdr_plen;
        q_item.kind     = tpds_pkg::KIND_NEW;
        if (parse_start > seg_len || seg_left < 17'(tpds_pkg::COMMON_HDR_BYTES))
        begin
            q_item.kind = tpds_pkg::KIND_SHORT;
        end
        else if (hdr_plen < 32'(tpds_pkg::COMMON_HDR_BYTES))
        begin
            q_item.kind = tpds_pkg::KIND_ERROR;
        end
        else
        begin
            unique case (hdr_type)
                tpds_pkg::PDU_IC_REQ, tpds_pkg::PDU_IC_RESP,
                tpds_pkg::PDU_H2C_TERM_REQ, tpds_pkg::PDU_C2H_TERM_REQ,
                tpds_pkg::PDU_CAPSULE_RESP, tpds_pkg::PDU_R2T:
                begin
                    q_item.kind = tpds_pkg::KIND_NEW;
                end
                tpds_pkg::PDU_CAPSULE_CMD, tpds_pkg::PDU_H2C_DATA,
                tpds_pkg::PDU_C2H_DATA:
                begin
                    // nonzero pdo splits the pdu into header and data parts
                    if (hdr_pdo != 8'd0)
                    begin
                        if (pdo_bad)
                        begin
                            q_item.kind = tpds_pkg::KIND_ERROR;
                        end
                        else
                        begin
                            q_item.head_len = {24'b0, hdr_pdo};
                        end
                    end
                end
                default:
                begin
                    q_item.kind = tpds_pkg::KIND_ERROR;
                end
            endcase
        end
    end

endmodule

>>> rtl/tpds_queue.sv
// short fifo between the classifier and the pdu tracker
// depends on tpds_pkg
module tpds_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tpds_pkg::queue_item_t push_item,
    output logic                  push_ready,
    input  logic                  pop,
    output logic                  pop_valid,
    output tpds_pkg::queue_item_t pop_item
);

    localparam int unsigned PTR_W = (tpds_pkg::QUEUE_DEPTH > 1)
                                  ? $clog2(tpds_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(tpds_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(tpds_pkg::QUEUE_DEPTH - 1);

    tpds_pkg::queue_item_t entry_reg [tpds_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(tpds_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/tpds_back.sv
// back stage: tracks the pdu in progress, picks the route and holds the result
// depends on tpds_pkg
module tpds_back #(
    parameter int ROUTE_SLOTS = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [1:0]            cfg_wdata,
    input  logic                  q_valid,
    input  tpds_pkg::queue_item_t q_item,
    output logic                  q_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,
    output logic [4:0]            m_axis_tuser
);

    logic [1:0]  control_route_reg;
    logic [1:0]  payload_route_reg;
    logic [31:0] pending_len_reg, pending_len_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [31:0] head_len_reg, head_len_next;

    logic                 out_valid_reg;
    logic [31:0]          out_len_reg, out_len_next;
    tpds_pkg::outcome_t   out_code_reg, out_code_next;
    logic                 out_rv_reg, out_rv_next;
    logic [1:0]           out_route_reg, out_route_next;

    logic        fire;
    logic [31:0] rest;
    logic [31:0] seg_ext;
    logic [31:0] take;

    assign fire  = q_valid && (!out_valid_reg || m_axis_tready);
    assign q_pop = fire;

    assign rest    = pending_len_reg - consumed_reg;
    assign seg_ext = {16'b0, q_item.seg_len};
    assign take    = (rest < seg_ext) ? rest : seg_ext;

    always_comb
    begin
        pending_len_next = pending_len_reg;
        consumed_next    = consumed_reg;
        head_len_next    = head_len_reg;
        out_len_next     = '0;
        out_code_next    = tpds_pkg::OUT_ERROR;
        out_rv_next      = 1'b0;
        out_route_next   = '0;
        if (pending_len_reg == '0)
        begin
            unique case (q_item.kind)
                tpds_pkg::KIND_SHORT:
                begin
                    out_code_next = tpds_pkg::OUT_NEED_MORE;
                end
                tpds_pkg::KIND_NEW:
                begin
                    // header part always goes out whole on the control route
                    head_len_next    = q_item.head_len;
                    consumed_next    = q_item.head_len;
                    pending_len_next = (q_item.head_len == q_item.pdu_len)
                                     ? '0 : q_item.pdu_len;
                    out_len_next     = q_item.head_len;
                    out_code_next    = tpds_pkg::OUT_CONSUMED;
                    out_rv_next      = ({30'b0, control_route_reg} < 32'(ROUTE_SLOTS));
                    out_route_next   = control_route_reg;
                end
                default:
                begin
                    out_code_next = tpds_pkg::OUT_ERROR;
                end
            endcase
        end
        else if (consumed_reg >= head_len_reg && consumed_reg < pending_len_reg)
        begin
            consumed_next    = consumed_reg + take;
            pending_len_next = (take == rest) ? '0 : pending_len_reg;
            out_len_next     = take;
            out_code_next    = tpds_pkg::OUT_CONSUMED;
            out_rv_next      = ({30'b0, payload_route_reg} < 32'(ROUTE_SLOTS));
            out_route_next   = payload_route_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_route_reg <= 2'd0;
            payload_route_reg <= 2'd1;
            pending_len_reg   <= '0;
            consumed_reg      <= '0;
            head_len_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    tpds_pkg::CFG_CONTROL_ROUTE: control_route_reg <= cfg_wdata;
                    tpds_pkg::CFG_PAYLOAD_ROUTE: payload_route_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (fire)
            begin
                pending_len_reg <= pending_len_next;
                consumed_reg    <= consumed_next;
                head_len_reg    <= head_len_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_len_reg   <= out_len_next;
            out_code_reg  <= out_code_next;
            out_rv_reg    <= out_rv_next;
            out_route_reg <= out_route_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_len_reg;
    assign m_axis_tuser  = {out_route_reg, out_rv_reg, out_code_reg};

endmodule

>>> rtl/tcp_pdu_header_data_splitter_unit.sv
// top level of the tcp pdu header/data splitter
// depends on tpds_pkg, tpds_front, tpds_queue, tpds_back
//
// usage:
//   s_axis carries one received segment descriptor per request: segment length,
//   parse start and the common pdu header fields (type, pdo, plen).
//   m_axis returns one result per request: bytes to consume, outcome
//   (need more, consumed, protocol error) and the route slot for those bytes.
//   cfg_wr_en/cfg_addr/cfg_wdata set the control route (0) and payload route (1);
//   write them only while no request is in flight.
// path: an accepted request is written into a queue entry, and the tracker
//   then pops it and registers its result into the m_axis output register.
// throughput: one request per cycle unless a held result is stalled on m_axis;
//   pdu tracker state updates combinationally (one subtract, one min, one add).
// reset: pdu state clears (awaiting a new pdu), control route 0, payload route 1,
//   queue empty, m_axis_tvalid low.
// stall: when m_axis_tready is low the result holds, the two-entry queue keeps
//   accepting until full, then s_axis_tready drops.
module tcp_pdu_header_data_splitter_unit #(
    parameter int ROUTE_SLOTS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // segment_length[15:0], parse_start[31:16], header_type[39:32],
    // header_data_offset[47:40], header_pdu_length[79:48]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // consume_length[31:0]
    output logic [31:0] m_axis_tdata,
    // outcome[1:0], route_valid[2], route_index[4:3]
    output logic [4:0]  m_axis_tuser
);

    logic                  q_ready;
    logic                  q_push;
    tpds_pkg::queue_item_t q_in;
    logic                  q_valid;
    logic                  q_pop;
    tpds_pkg::queue_item_t q_out;

    tpds_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_ready       (q_ready),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    tpds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_out)
    );

    tpds_back #(
        .ROUTE_SLOTS (ROUTE_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .q_valid       (q_valid),
        .q_item        (q_out),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> rtl/tpds_checker.sv
// port-level checks for the tcp pdu header/data splitter, bound to the top level
// depends on tpds_pkg and tcp_pdu_header_data_splitter_unit_defines.svh
`include "tcp_pdu_header_data_splitter_unit_defines.svh"

module tpds_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [4:0]  m_axis_tuser
);

    // a stalled result stays offered
    `TPDS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // only a consumed outcome carries a length
    `TPDS_ASSERT_NOW(a_len_zero, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser[1:0] != tpds_pkg::OUT_CONSUMED),
        m_axis_tdata == 32'd0)

    // need-more and error results carry no route
    `TPDS_ASSERT_NOW(a_no_route, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser[1:0] != tpds_pkg::OUT_CONSUMED),
        (m_axis_tuser[4:2] == 3'd0))

endmodule

bind tcp_pdu_header_data_splitter_unit tpds_checker u_tpds_checker (.*);
